FILE: sv/sd_card_spi_host_controller_macros.svh
// ----------------------------------------------------------------------------
// SD card SPI host controller assertion macros
// Concurrent assertion helpers clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SD_CARD_SPI_HOST_CONTROLLER_MACROS_SVH
`define SD_CARD_SPI_HOST_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define SDH_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sdh assertion failed");
`define SDH_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("sdh forbidden condition");
`else
`define SDH_ASSERT(label, prop)
`define SDH_NEVER(label, cond)
`endif

`endif

FILE: sv/sdh_pkg.sv
// ----------------------------------------------------------------------------
// SD card SPI host controller package
// Sequencer phases, byte-exchange stages, codes and constants.
// ----------------------------------------------------------------------------
package sdh_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned BUF_AW      = 9;

    typedef enum logic [4:0] {
        PH_IDLE, PH_CLK, PH_CMD0, PH_CMD8, PH_V1_55, PH_V1_41, PH_V2_58A, PH_V2_55,
        PH_V2_41, PH_V2_58B, PH_CMD9, PH_CSD, PH_CMD16, PH_RD_CMD, PH_RD_DATA,
        PH_WR_CMD, PH_WR_DATA
    } phase_t;

    typedef enum logic [3:0] {
        STG_SEND, STG_POLL, STG_TAIL, STG_GAP, STG_TOKEN, STG_DATA, STG_CRC,
        STG_WTOKEN, STG_WDATA, STG_WCRC, STG_WRESP, STG_BUSY
    } stage_t;

    localparam logic [1:0] KIND_REQ  = 2'd0;
    localparam logic [1:0] KIND_RX   = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_NO_IDLE    = 3'd1;
    localparam logic [2:0] STS_NOT_SD     = 3'd2;
    localparam logic [2:0] STS_INIT_TMO   = 3'd3;
    localparam logic [2:0] STS_CMD_ERR    = 3'd4;
    localparam logic [2:0] STS_WR_REJECT  = 3'd5;
    localparam logic [2:0] STS_CSD_UNK    = 3'd6;
    localparam logic [2:0] STS_BLKLEN_ERR = 3'd7;

    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD = 6'd9;
    localparam logic [5:0] CMD_BLKLEN   = 6'd16;
    localparam logic [5:0] CMD_RD_BLK   = 6'd17;
    localparam logic [5:0] CMD_WR_BLK   = 6'd24;
    localparam logic [5:0] CMD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP      = 6'd55;
    localparam logic [5:0] CMD_READ_OCR = 6'd58;

    localparam logic [1:0] REG_RESP_POLL = 2'd0;
    localparam logic [1:0] REG_INIT_RTRY = 2'd1;
    localparam logic [1:0] REG_CMD8_POLL = 2'd2;

    localparam logic [7:0]  BYTE_IDLE    = 8'hFF;
    localparam logic [7:0]  BYTE_TOKEN   = 8'hFE;
    localparam logic [7:0]  CRC_CMD0     = 8'h95;
    localparam logic [7:0]  CRC_CMD8     = 8'h87;
    localparam logic [7:0]  CMD_PREFIX   = 8'h40;
    localparam logic [31:0] ARG_CMD8     = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
    localparam logic [31:0] ARG_BLKLEN   = 32'd512;
    localparam logic [4:0]  DRESP_MASKED = 5'h05;

endpackage

FILE: sv/sd_card_spi_host_controller.sv
// Inputs pass through the input register and then the result register to m_tvalid.
// Throughput: one item per cycle unless m_tready holds the result register; each item
// is processed in a single pass between the input register and the result register.
// Write-buffer bytes come from a 512x8 memory with registered read data.
// Reset (aresetn low, synchronous): idle, counters cleared, slow clock,
// limits 5000 / 5000 / 5000000.
// ----------------------------------------------------------------------------
// SD card SPI host controller
// SPI-mode SD card init, single-block read and write, one byte per transfer.
// ----------------------------------------------------------------------------
`include "sd_card_spi_host_controller_macros.svh"

module sd_card_spi_host_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0], block_number[33:2], rx_byte[41:34], load_index[50:42], load_byte[58:51]
    input  logic [63:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_valid[0], tx_byte[8:1], select_low[9], fast_clock[10], read_valid[11],
    // read_data[19:12], done_res[20], status[23:21], card_type[25:24], sector_count[57:26]
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdh_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_kind_reg, in_op_reg;
    logic [31:0] in_blk_reg;
    logic [7:0]  in_rx_reg, in_lbyte_reg;
    logic [8:0]  in_lidx_reg;
    logic        fire;

    logic [15:0] resp_lim_reg, retry_lim_reg;
    logic [22:0] cmd8_lim_reg;

    phase_t      phase_reg, phase_next;
    stage_t      stage_reg, stage_next;
    logic [1:0]  version_reg, version_next;
    logic [5:0]  cidx_reg, cidx_next;
    logic [7:0]  cresp_reg, cresp_next;
    logic        ctmo_reg, ctmo_next;
    logic        baddr_reg, baddr_next;
    logic        fast_reg, fast_next;
    logic [9:0]  fc_reg, fc_next, fc_inc;
    logic [22:0] poll_reg, poll_next, poll_inc;
    logic [15:0] retry_reg, retry_next, retry_inc;
    logic [31:0] sect_reg, sect_next;
    logic [31:0] arg_reg, arg_next;
    logic [7:0]  csd_reg [16];
    logic [127:0] csd_vec;
    logic        csd_we;

    logic [7:0]  wbuf [BLOCK_BYTES];
    logic [7:0]  mem_q_reg;
    logic [BUF_AW-1:0] mem_addr;
    logic        load_we, use_mem;

    logic        o_txv, o_sel, o_rv, o_done;
    logic [7:0]  o_tx, o_rd;
    logic [2:0]  o_st;

    logic        st_req, fin_req, cd_req, csd_req;
    phase_t      st_ph;
    logic [5:0]  st_idx;
    logic [31:0] st_arg;
    logic [2:0]  fin_st;
    logic        cd_tmo;
    logic [7:0]  cd_resp;
    logic        r_is0, r_is1;
    logic [22:0] poll_lim;

    logic [4:0]  csd_sh;
    logic [36:0] csd_cap0;
    logic [32:0] csd_cap1;

    logic        res_valid_reg, res_txv_reg, res_mem_reg, res_sel_reg, res_fast_reg;
    logic        res_rv_reg, res_done_reg;
    logic [7:0]  res_tx_reg, res_rd_reg;
    logic [2:0]  res_st_reg;
    logic [1:0]  res_ct_reg;
    logic [31:0] res_sc_reg;
    logic [7:0]  out_tx;

    assign fire     = in_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= s_tuser;
            in_op_reg    <= s_tdata[1:0];
            in_blk_reg   <= s_tdata[33:2];
            in_rx_reg    <= s_tdata[41:34];
            in_lidx_reg  <= s_tdata[50:42];
            in_lbyte_reg <= s_tdata[58:51];
        end
    end

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_lim_reg  <= 16'd5000;
            retry_lim_reg <= 16'd5000;
            cmd8_lim_reg  <= 23'd5000000;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_RESP_POLL: resp_lim_reg  <= pwdata[15:0];
                REG_INIT_RTRY: retry_lim_reg <= pwdata[15:0];
                REG_CMD8_POLL: cmd8_lim_reg  <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RESP_POLL: prdata = {16'd0, resp_lim_reg};
            REG_INIT_RTRY: prdata = {16'd0, retry_lim_reg};
            REG_CMD8_POLL: prdata = {9'd0, cmd8_lim_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // CSD decode
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            csd_vec[i*8 +: 8] = csd_reg[15-i];
        end
        csd_sh   = {2'b00, csd_vec[49:47]} + 5'd2 + {1'b0, csd_vec[83:80]};
        csd_cap0 = {24'd0, csd_vec[73:62] + 12'd1 == 12'd0 ? 13'h1000
                                                         : {1'b0, csd_vec[73:62] + 12'd1}}
                   << csd_sh;
        csd_cap1 = {({1'b0, csd_vec[69:48]} + 23'd1), 10'd0};
    end

    always_comb begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        version_next = version_reg;
        cidx_next    = cidx_reg;
        cresp_next   = cresp_reg;
        ctmo_next    = ctmo_reg;
        baddr_next   = baddr_reg;
        fast_next    = fast_reg;
        fc_next      = fc_reg;
        poll_next    = poll_reg;
        retry_next   = retry_reg;
        sect_next    = sect_reg;
        arg_next     = arg_reg;
        fc_inc       = fc_reg + 10'd1;
        poll_inc     = poll_reg + 23'd1;
        retry_inc    = retry_reg + 16'd1;
        poll_lim     = (cidx_reg == CMD_IF_COND) ? cmd8_lim_reg : {7'd0, resp_lim_reg};
        o_txv = 1'b0; o_tx = 8'd0; o_sel = 1'b0; o_rv = 1'b0; o_rd = 8'd0;
        o_done = 1'b0; o_st = STS_OK;
        use_mem  = 1'b0;
        mem_addr = '0;
        load_we  = 1'b0;
        csd_we   = 1'b0;
        st_req = 1'b0; st_ph = PH_IDLE; st_idx = CMD_GO_IDLE; st_arg = 32'd0;
        fin_req = 1'b0; fin_st = STS_OK;
        cd_req = 1'b0; cd_tmo = 1'b0; cd_resp = 8'd0;
        csd_req = 1'b0;

        if (fire) begin
            if (in_kind_reg == KIND_REQ && phase_reg == PH_IDLE) begin
                case (in_op_reg)
                    OP_INIT: begin
                        version_next = 2'd0; sect_next = 32'd0; baddr_next = 1'b0;
                        fast_next = 1'b0; phase_next = PH_CLK; fc_next = 10'd0;
                        o_txv = 1'b1; o_tx = BYTE_IDLE;
                    end
                    OP_READ: begin
                        st_req = 1'b1; st_ph = PH_RD_CMD; st_idx = CMD_RD_BLK;
                        st_arg = baddr_reg ? in_blk_reg : {in_blk_reg[22:0], 9'd0};
                    end
                    OP_WRITE: begin
                        st_req = 1'b1; st_ph = PH_WR_CMD; st_idx = CMD_WR_BLK;
                        st_arg = baddr_reg ? in_blk_reg : {in_blk_reg[22:0], 9'd0};
                    end
                    default: begin
                        fin_req = 1'b1; fin_st = STS_CMD_ERR;
                    end
                endcase
            end else if (in_kind_reg == KIND_RX && phase_reg != PH_IDLE) begin
                if (phase_reg == PH_CLK) begin
                    fc_next = fc_inc;
                    if (fc_inc < 10'd16) begin
                        o_txv = 1'b1; o_tx = BYTE_IDLE;
                    end else begin
                        st_req = 1'b1; st_ph = PH_CMD0; st_idx = CMD_GO_IDLE; st_arg = 32'd0;
                    end
                end else begin
                    case (stage_reg)
                        STG_SEND: begin
                            fc_next = fc_inc;
                            o_txv = 1'b1; o_sel = 1'b1;
                            if (fc_inc < 10'd6) begin
                                case (fc_inc[2:0])
                                    3'd1: o_tx = arg_reg[31:24];
                                    3'd2: o_tx = arg_reg[23:16];
                                    3'd3: o_tx = arg_reg[15:8];
                                    3'd4: o_tx = arg_reg[7:0];
                                    default: o_tx = (cidx_reg == CMD_IF_COND) ? CRC_CMD8
                                                                               : CRC_CMD0;
                                endcase
                            end else begin
                                stage_next = STG_POLL; poll_next = 23'd0; o_tx = BYTE_IDLE;
                            end
                        end
                        STG_POLL: begin
                            o_txv = 1'b1; o_tx = BYTE_IDLE;
                            if (!in_rx_reg[7]) begin
                                cresp_next = in_rx_reg; ctmo_next = 1'b0;
                                if (cidx_reg == CMD_IF_COND || cidx_reg == CMD_READ_OCR) begin
                                    stage_next = STG_TAIL; fc_next = 10'd0; o_sel = 1'b1;
                                end else if (cidx_reg == CMD_SEND_CSD) begin
                                    o_txv = 1'b0; o_tx = 8'd0;
                                    cd_req = 1'b1; cd_resp = in_rx_reg;
                                end else begin
                                    stage_next = STG_GAP;
                                end
                            end else begin
                                poll_next = poll_inc;
                                if (poll_inc >= poll_lim) begin
                                    ctmo_next = 1'b1; stage_next = STG_GAP;
                                end else begin
                                    o_sel = 1'b1;
                                end
                            end
                        end
                        STG_TAIL: begin
                            fc_next = fc_inc; o_txv = 1'b1; o_tx = BYTE_IDLE;
                            if (fc_inc < 10'd4) o_sel = 1'b1;
                            else stage_next = STG_GAP;
                        end
                        STG_GAP: begin
                            if (phase_reg == PH_CSD) begin
                                csd_req = 1'b1;
                            end else if (phase_reg == PH_RD_DATA) begin
                                fin_req = 1'b1; fin_st = STS_OK;
                            end else if (phase_reg == PH_WR_DATA) begin
                                fin_req = 1'b1;
                                fin_st = (cresp_reg != 8'd0) ? STS_WR_REJECT : STS_OK;
                            end else begin
                                cd_req = 1'b1; cd_tmo = ctmo_reg; cd_resp = cresp_reg;
                            end
                        end
                        STG_TOKEN: begin
                            if (in_rx_reg == BYTE_TOKEN) begin
                                stage_next = STG_DATA; fc_next = 10'd0;
                            end
                            o_txv = 1'b1; o_tx = BYTE_IDLE; o_sel = 1'b1;
                        end
                        STG_DATA: begin
                            fc_next = fc_inc;
                            if (phase_reg == PH_CSD) begin
                                csd_we = 1'b1;
                                if (fc_inc >= 10'd16) begin
                                    stage_next = STG_CRC; fc_next = 10'd0;
                                end
                            end else begin
                                o_rv = 1'b1; o_rd = in_rx_reg;
                                if (fc_inc >= 10'(BLOCK_BYTES)) begin
                                    stage_next = STG_CRC; fc_next = 10'd0;
                                end
                            end
                            o_txv = 1'b1; o_tx = BYTE_IDLE; o_sel = 1'b1;
                        end
                        STG_CRC: begin
                            fc_next = fc_inc; o_txv = 1'b1; o_tx = BYTE_IDLE;
                            if (fc_inc < 10'd2) o_sel = 1'b1;
                            else stage_next = STG_GAP;
                        end
                        STG_WTOKEN: begin
                            stage_next = STG_WDATA; fc_next = 10'd0;
                            o_txv = 1'b1; o_sel = 1'b1; use_mem = 1'b1; mem_addr = '0;
                        end
                        STG_WDATA: begin
                            fc_next = fc_inc; o_txv = 1'b1; o_sel = 1'b1;
                            if (fc_inc < 10'(BLOCK_BYTES)) begin
                                use_mem = 1'b1; mem_addr = fc_inc[BUF_AW-1:0];
                            end else begin
                                stage_next = STG_WCRC; fc_next = 10'd0; o_tx = BYTE_IDLE;
                            end
                        end
                        STG_WCRC: begin
                            fc_next = fc_inc; o_txv = 1'b1; o_tx = BYTE_IDLE; o_sel = 1'b1;
                            if (fc_inc >= 10'd2) stage_next = STG_WRESP;
                        end
                        STG_WRESP: begin
                            o_txv = 1'b1; o_tx = BYTE_IDLE;
                            if (in_rx_reg[4:0] != DRESP_MASKED) begin
                                cresp_next = 8'd1; stage_next = STG_GAP;
                            end else begin
                                cresp_next = 8'd0; stage_next = STG_BUSY; o_sel = 1'b1;
                            end
                        end
                        STG_BUSY: begin
                            o_txv = 1'b1; o_tx = BYTE_IDLE;
                            if (in_rx_reg == 8'd0) o_sel = 1'b1;
                            else stage_next = STG_GAP;
                        end
                        default: begin
                            fin_req = 1'b1; fin_st = STS_CMD_ERR;
                        end
                    endcase
                end
            end else if (in_kind_reg == KIND_LOAD) begin
                load_we = 1'b1;
            end
        end

        r_is0 = !cd_tmo && cd_resp == 8'h00;
        r_is1 = !cd_tmo && cd_resp == 8'h01;

        if (cd_req) begin
            case (phase_reg)
                PH_CMD0: begin
                    if (!r_is1) begin
                        fin_req = 1'b1; fin_st = STS_NO_IDLE;
                    end else begin
                        st_req = 1'b1; st_ph = PH_CMD8; st_idx = CMD_IF_COND; st_arg = ARG_CMD8;
                    end
                end
                PH_CMD8: begin
                    retry_next = 16'd0;
                    if (r_is1) begin
                        st_req = 1'b1; st_ph = PH_V2_58A; st_idx = CMD_READ_OCR;
                    end else if (!cd_tmo && cd_resp == 8'h05) begin
                        st_req = 1'b1; st_ph = PH_V1_55; st_idx = CMD_APP;
                    end else begin
                        fin_req = 1'b1; fin_st = STS_NOT_SD;
                    end
                end
                PH_V1_55: begin
                    st_req = 1'b1; st_ph = PH_V1_41; st_idx = CMD_OP_COND;
                end
                PH_V1_41: begin
                    if (r_is0) begin
                        version_next = 2'd1; baddr_next = 1'b0;
                        st_req = 1'b1; st_ph = PH_CMD9; st_idx = CMD_SEND_CSD;
                    end else begin
                        retry_next = retry_inc;
                        if (retry_inc >= retry_lim_reg) begin
                            fin_req = 1'b1; fin_st = STS_INIT_TMO;
                        end else begin
                            st_req = 1'b1; st_ph = PH_V1_55; st_idx = CMD_APP;
                        end
                    end
                end
                PH_V2_58A: begin
                    st_req = 1'b1; st_ph = PH_V2_55; st_idx = CMD_APP;
                end
                PH_V2_55: begin
                    st_req = 1'b1; st_ph = PH_V2_41; st_idx = CMD_OP_COND; st_arg = ARG_HCS;
                end
                PH_V2_41: begin
                    if (r_is0) begin
                        st_req = 1'b1; st_ph = PH_V2_58B; st_idx = CMD_READ_OCR;
                    end else begin
                        retry_next = retry_inc;
                        if (retry_inc >= retry_lim_reg) begin
                            fin_req = 1'b1; fin_st = STS_INIT_TMO;
                        end else begin
                            st_req = 1'b1; st_ph = PH_V2_58A; st_idx = CMD_READ_OCR;
                        end
                    end
                end
                PH_V2_58B: begin
                    version_next = 2'd2; baddr_next = 1'b1;
                    st_req = 1'b1; st_ph = PH_CMD9; st_idx = CMD_SEND_CSD;
                end
                PH_CMD9: begin
                    if (!r_is0) begin
                        sect_next = 32'd0; fin_req = 1'b1; fin_st = STS_CMD_ERR;
                    end else begin
                        phase_next = PH_CSD; stage_next = STG_TOKEN; fc_next = 10'd0;
                        o_txv = 1'b1; o_tx = BYTE_IDLE; o_sel = 1'b1;
                    end
                end
                PH_CMD16: begin
                    if (!r_is0) begin
                        fin_req = 1'b1; fin_st = STS_BLKLEN_ERR;
                    end else begin
                        fast_next = 1'b1; fin_req = 1'b1; fin_st = STS_OK;
                    end
                end
                PH_RD_CMD: begin
                    if (!r_is0) begin
                        fin_req = 1'b1; fin_st = STS_CMD_ERR;
                    end else begin
                        phase_next = PH_RD_DATA; stage_next = STG_TOKEN; fc_next = 10'd0;
                        o_txv = 1'b1; o_tx = BYTE_IDLE; o_sel = 1'b1;
                    end
                end
                PH_WR_CMD: begin
                    if (!r_is0) begin
                        fin_req = 1'b1; fin_st = STS_CMD_ERR;
                    end else begin
                        phase_next = PH_WR_DATA; stage_next = STG_WTOKEN;
                        o_txv = 1'b1; o_tx = BYTE_TOKEN; o_sel = 1'b1;
                    end
                end
                default: begin
                    fin_req = 1'b1; fin_st = STS_CMD_ERR;
                end
            endcase
        end

        if (csd_req) begin
            case (csd_vec[127:126])
                2'd0: begin
                    baddr_next = 1'b0;
                    sect_next  = {4'd0, csd_cap0[36:9]};
                    st_req = 1'b1; st_ph = PH_CMD16; st_idx = CMD_BLKLEN; st_arg = ARG_BLKLEN;
                end
                2'd1: begin
                    baddr_next = 1'b1;
                    sect_next  = csd_cap1[32] ? 32'hFFFF_FFFF : csd_cap1[31:0];
                    st_req = 1'b1; st_ph = PH_CMD16; st_idx = CMD_BLKLEN; st_arg = ARG_BLKLEN;
                end
                default: begin
                    sect_next = 32'd0; fin_req = 1'b1; fin_st = STS_CSD_UNK;
                end
            endcase
        end

        if (st_req) begin
            phase_next = st_ph; cidx_next = st_idx; arg_next = st_arg;
            stage_next = STG_SEND; fc_next = 10'd0; poll_next = 23'd0;
            o_txv = 1'b1; o_tx = CMD_PREFIX | {2'b00, st_idx}; o_sel = 1'b1;
        end
        if (fin_req) begin
            phase_next = PH_IDLE; stage_next = STG_SEND;
            o_done = 1'b1; o_st = fin_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            stage_reg   <= STG_SEND;
            version_reg <= 2'd0;
            cidx_reg    <= 6'd0;
            cresp_reg   <= 8'd0;
            ctmo_reg    <= 1'b0;
            baddr_reg   <= 1'b0;
            fast_reg    <= 1'b0;
            fc_reg      <= 10'd0;
            poll_reg    <= 23'd0;
            retry_reg   <= 16'd0;
            sect_reg    <= 32'd0;
            arg_reg     <= 32'd0;
        end else begin
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            version_reg <= version_next;
            cidx_reg    <= cidx_next;
            cresp_reg   <= cresp_next;
            ctmo_reg    <= ctmo_next;
            baddr_reg   <= baddr_next;
            fast_reg    <= fast_next;
            fc_reg      <= fc_next;
            poll_reg    <= poll_next;
            retry_reg   <= retry_next;
            sect_reg    <= sect_next;
            arg_reg     <= arg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (csd_we) begin
            csd_reg[fc_reg[3:0]] <= in_rx_reg;
        end
    end

    // write buffer
    always_ff @(posedge aclk) begin
        if (load_we) begin
            wbuf[in_lidx_reg] <= in_lbyte_reg;
        end
        if (fire) begin
            mem_q_reg <= wbuf[mem_addr];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (fire) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
        if (fire) begin
            res_txv_reg  <= o_txv;
            res_tx_reg   <= o_tx;
            res_mem_reg  <= use_mem;
            res_sel_reg  <= o_sel;
            res_fast_reg <= fast_next;
            res_rv_reg   <= o_rv;
            res_rd_reg   <= o_rd;
            res_done_reg <= o_done;
            res_st_reg   <= o_st;
            res_ct_reg   <= version_next;
            res_sc_reg   <= sect_next;
        end
    end

    assign out_tx   = res_mem_reg ? mem_q_reg : res_tx_reg;
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {6'd0, res_sc_reg, res_ct_reg, res_st_reg, res_done_reg, res_rd_reg,
                       res_rv_reg, res_fast_reg, res_sel_reg, out_tx, res_txv_reg};

    `SDH_ASSERT(a_done_goes_idle, (fire && o_done) |=> (phase_reg == PH_IDLE))
    `SDH_ASSERT(a_fast_needs_ok, (fire && fast_next && !fast_reg) |-> (o_done && o_st == STS_OK))
    `SDH_NEVER(a_stall_no_fire, res_valid_reg && !m_tready && fire)

endmodule
